>>> design/clipped_shape_fill_raster_top_assert.svh
// Assertion macros shared by the framebuffer raster block.
`ifndef CLIPPED_SHAPE_FILL_RASTER_TOP_ASSERT_SVH
`define CLIPPED_SHAPE_FILL_RASTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSFR_ASSERT_IMP(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSFR_ASSERT_NXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/csfr_pkg.sv
`timescale 1ns / 1ps

package csfr_pkg;

  localparam int CANVAS_SIZE_DEFAULT = 128;

  // Signed working width for coordinates and window limits.
  localparam int POS_WIDTH = 12;
  // Row count of one shape: a diamond spans up to 2 * 255 + 1 rows.
  localparam int ROWS_WIDTH = 10;

  typedef logic [2:0] mode_t;
  typedef logic [7:0] pixel_t;
  typedef logic [0:0] cfg_index_t;

  localparam mode_t MODE_RECT    = 3'd0;
  localparam mode_t MODE_UP_TRI  = 3'd1;
  localparam mode_t MODE_DOWN_TRI = 3'd2;
  localparam mode_t MODE_DIAMOND = 3'd3;
  localparam mode_t MODE_CLEAR   = 3'd4;
  localparam mode_t MODE_READ    = 3'd5;

  localparam cfg_index_t REG_CLIP_WIDTH  = 1'b0;
  localparam cfg_index_t REG_CLIP_HEIGHT = 1'b1;

  localparam pixel_t BLANK_BYTE = 8'd46;
  localparam logic [7:0] CLIP_RESET = 8'd128;

endpackage

>>> design/csfr_ram.sv
`timescale 1ns / 1ps

module csfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/clipped_shape_fill_raster_top.sv
`timescale 1ns / 1ps
//
// Channel   Direction  Signals                                       Transaction
// command   in         start, busy, mode, x_pos, y_pos, width,       start high, busy low
//                      height, brush
// result    out        result_valid, read_value, in_bounds           result_valid high
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data     cfg_valid and cfg_ready
//
// Order: a shape steps its rows one by one and writes each clipped span a pixel at a time,
// then shows its result; a pixel read registers the address, then shows the stored byte; a clear
// sweeps every address of the store first. The frame store has a single write port.
// Reset: synchronous; after reset every address of the store is swept to '.', and during the sweep
// busy is high and no command is taken (configuration writes still are).
// Stalls: the receiver cannot stall; each result is shown for exactly one cycle.
//
module clipped_shape_fill_raster_top #(
  parameter int CANVAS_SIZE = csfr_pkg::CANVAS_SIZE_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Command channel
  input  logic                   start,
  output logic                   busy,
  input  csfr_pkg::mode_t        mode,
  input  logic signed [8:0]      x_pos,
  input  logic signed [8:0]      y_pos,
  input  logic [7:0]             width,
  input  logic [7:0]             height,
  input  csfr_pkg::pixel_t       brush,
  // Result channel
  output logic                   result_valid,
  output csfr_pkg::pixel_t       read_value,
  output logic                   in_bounds,
  // Configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  csfr_pkg::cfg_index_t   cfg_index,
  input  logic [7:0]             cfg_data
);

  import csfr_pkg::*;

  `include "clipped_shape_fill_raster_top_assert.svh"

  // Store geometry. Rows and columns share one index width; the store is row major.
  localparam int DEPTH = CANVAS_SIZE * CANVAS_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (CANVAS_SIZE > 1) ? $clog2(CANVAS_SIZE) : 1;
  localparam int PW    = POS_WIDTH;

  localparam logic [AW-1:0] CANVAS_AW  = AW'(CANVAS_SIZE);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [PW-1:0] CANVAS_LIM = PW'(CANVAS_SIZE);
  localparam logic signed [PW-1:0] ZERO_S = '0;
  localparam logic signed [PW-1:0] ONE_S  = PW'(1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CLEAR     = 3'd1;
  localparam logic [2:0] ST_ROW       = 3'd2;
  localparam logic [2:0] ST_SPAN      = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;
  localparam logic [2:0] ST_READ_DATA = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

  logic [2:0]             state;
  logic [AW-1:0]          clr_cnt;
  logic                   clear_cmd;

  // Configuration registers.
  logic [7:0]             clip_width;
  logic [7:0]             clip_height;

  // Shape walk registers.
  logic signed [PW-1:0]   x0;
  logic signed [PW-1:0]   y_cur;
  logic [7:0]             w_reg;
  logic [7:0]             h_reg;
  logic [7:0]             hw;
  logic                   grow;
  logic [ROWS_WIDTH-1:0]  rows_left;
  logic                   is_rect;
  logic                   is_down;
  pixel_t                 brush_reg;
  logic                   rd_ok;

  // Current pixel position and the last column of the span.
  logic [CW-1:0]          row_idx;
  logic [CW-1:0]          col;
  logic [CW-1:0]          col_end;

  // Effective window: the clip registers, capped at the canvas.
  logic [PW-1:0]          clip_w_ext;
  logic [PW-1:0]          clip_h_ext;
  logic [PW-1:0]          lim_x_u;
  logic [PW-1:0]          lim_y_u;
  logic signed [PW-1:0]   lim_x;
  logic signed [PW-1:0]   lim_y;

  // Incoming coordinates, sign extended.
  logic signed [PW-1:0]   x_in;
  logic signed [PW-1:0]   y_in;
  logic                   rd_ok_in;

  // Span of the current row before and after clipping.
  logic signed [PW-1:0]   hw_s;
  logic signed [PW-1:0]   w_s;
  logic signed [PW-1:0]   xa;
  logic signed [PW-1:0]   xb;
  logic signed [PW-1:0]   xa_c;
  logic signed [PW-1:0]   xb_c;
  logic                   span_ok;
  logic [ROWS_WIDTH-1:0]  rows_in;

  // Frame store port signals.
  logic [AW-1:0]          pix_addr;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  pixel_t                 ram_wdata;
  pixel_t                 ram_rdata;

  // Conditions watched by the assertions.
  logic                   in_span;
  logic                   span_in_window;
  logic                   read_echo;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign clip_w_ext = PW'(clip_width);
  assign clip_h_ext = PW'(clip_height);
  assign lim_x_u    = (clip_w_ext < CANVAS_LIM) ? clip_w_ext : CANVAS_LIM;
  assign lim_y_u    = (clip_h_ext < CANVAS_LIM) ? clip_h_ext : CANVAS_LIM;
  assign lim_x      = $signed(lim_x_u);
  assign lim_y      = $signed(lim_y_u);

  assign x_in = {{(PW-9){x_pos[8]}}, x_pos};
  assign y_in = {{(PW-9){y_pos[8]}}, y_pos};
  assign rd_ok_in = (x_in >= ZERO_S) && (y_in >= ZERO_S) && (x_in < lim_x) && (y_in < lim_y);

  // A rectangle has no rows when its width is zero; a diamond has 2h + 1 rows.
  always_comb begin
    case (mode)
      MODE_RECT:    rows_in = (width == 8'd0) ? '0 : ROWS_WIDTH'(height);
      MODE_DIAMOND: rows_in = ROWS_WIDTH'({height, 1'b1});
      default:      rows_in = ROWS_WIDTH'(height);
    endcase
  end

  // Rectangles span a fixed column range; the other shapes a half-width about x0.
  assign hw_s = $signed(PW'(hw));
  assign w_s  = $signed(PW'(w_reg));
  assign xa   = is_rect ? x0 : (x0 - hw_s);
  assign xb   = is_rect ? (x0 + w_s - ONE_S) : (x0 + hw_s);
  assign xa_c = (xa < ZERO_S) ? ZERO_S : xa;
  assign xb_c = (xb > (lim_x - ONE_S)) ? (lim_x - ONE_S) : xb;
  assign span_ok = (y_cur >= ZERO_S) && (y_cur < lim_y) && (xa_c <= xb_c);

  // Row-major address of the current pixel; the multiplier is by a constant.
  assign pix_addr = AW'(AW'(row_idx) * CANVAS_AW) + AW'(col);

  assign ram_we    = (state == ST_CLEAR) || (state == ST_SPAN);
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt : pix_addr;
  assign ram_wdata = (state == ST_CLEAR) ? BLANK_BYTE : brush_reg;

  csfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  // Configuration writes are taken in any cycle; the user keeps them to idle periods.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_width  <= CLIP_RESET;
      clip_height <= CLIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLIP_WIDTH:  clip_width  <= cfg_data;
        REG_CLIP_HEIGHT: clip_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command sequencer. A shape is walked one row at a time: the ROW state clips the
  // row's span and steps the row state, then SPAN writes one pixel per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      clear_cmd    <= 1'b0;
      result_valid <= 1'b0;
      read_value   <= '0;
      in_bounds    <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      read_value   <= '0;
      in_bounds    <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            x0        <= x_in;
            y_cur     <= y_in;
            w_reg     <= width;
            h_reg     <= height;
            hw        <= '0;
            grow      <= 1'b1;
            rows_left <= rows_in;
            is_rect   <= (mode == MODE_RECT);
            is_down   <= (mode == MODE_DOWN_TRI);
            brush_reg <= brush;
            rd_ok     <= rd_ok_in;
            row_idx   <= y_in[CW-1:0];
            col       <= x_in[CW-1:0];
            case (mode)
              MODE_RECT, MODE_UP_TRI, MODE_DOWN_TRI, MODE_DIAMOND: begin
                state <= ST_ROW;
              end
              MODE_CLEAR: begin
                clr_cnt   <= '0;
                clear_cmd <= 1'b1;
                state     <= ST_CLEAR;
              end
              MODE_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ADDR) begin
            // The sweep after reset gives no result; a clear command does.
            state     <= clear_cmd ? ST_DONE : ST_IDLE;
            clear_cmd <= 1'b0;
          end
        end
        ST_ROW: begin
          if (rows_left == '0) begin
            state <= ST_DONE;
          end else begin
            rows_left <= rows_left - 1'b1;
            y_cur     <= is_down ? (y_cur - ONE_S) : (y_cur + ONE_S);
            // A diamond widens until its half-width reaches the height, then narrows.
            if (grow && (hw != h_reg)) begin
              hw <= hw + 1'b1;
            end else begin
              hw   <= hw - 1'b1;
              grow <= 1'b0;
            end
            if (span_ok) begin
              row_idx <= y_cur[CW-1:0];
              col     <= xa_c[CW-1:0];
              col_end <= xb_c[CW-1:0];
              state   <= ST_SPAN;
            end
          end
        end
        ST_SPAN: begin
          if (col == col_end) begin
            state <= ST_ROW;
          end else begin
            col <= col + 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_READ_DATA;
        end
        ST_READ_DATA: begin
          result_valid <= 1'b1;
          read_value   <= rd_ok ? ram_rdata : '0;
          in_bounds    <= rd_ok;
          state        <= ST_IDLE;
        end
        ST_DONE: begin
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_span        = (state == ST_SPAN);
  assign span_in_window = (PW'(col) < lim_x_u) && (PW'(row_idx) < lim_y_u);
  assign read_echo      = result_valid && (read_value == ram_rdata);

  `CSFR_ASSERT_IMP(a_write_clipped, clk, rst, in_span, span_in_window, "write off the window")
  `CSFR_ASSERT_IMP(a_span_order, clk, rst, in_span, col <= col_end, "span column passed its end")
  `CSFR_ASSERT_IMP(a_result_idle, clk, rst, result_valid, !busy, "result while busy")
  `CSFR_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accept left busy low")
  `CSFR_ASSERT_IMP(a_bounds_strobe, clk, rst, in_bounds, read_echo, "in_bounds without a read")

endmodule
